// ===== sv/ueec_pkg.sv =====
// Package: shared types, constants and the emoji range function for the UTF-16 decoder.
`timescale 1ns / 1ps

package ueec_pkg;

    // Surrogate ranges and pair offset
    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] PAIR_BASE     = 21'h10000;
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;

    // Supplementary emoji block and its emoji subrange
    localparam logic [20:0] SUPP_BLOCK_MIN = 21'h1F000;
    localparam logic [20:0] SUPP_BLOCK_MAX = 21'h1FFFF;
    localparam logic [20:0] SUPP_EMOJI_MIN = 21'h1F100;
    localparam logic [20:0] SUPP_EMOJI_MAX = 21'h1FAFF;

    // Input request: one code unit
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } in_item_t;

    // Output request: one classified code point
    typedef struct packed {
        logic [20:0] codepoint;
        logic        is_emoji;
        logic        message_has_emoji;
        logic        last_point;
    } out_item_t;

    // Queue entry: an optional lone held high surrogate, then an optional code point
    typedef struct packed {
        logic        has_held;
        logic [9:0]  held;
        logic        has_cp;
        logic [20:0] cp;
        logic        last;
    } queue_entry_t;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic in_range(input logic [20:0] c, input logic [20:0] lo,
                                      input logic [20:0] hi);
        in_range = (c >= lo) && (c <= hi);
    endfunction

    // Fixed emoji range table
    function automatic logic in_emoji_table(input logic [20:0] c);
        logic hit;
        if (in_range(c, SUPP_BLOCK_MIN, SUPP_BLOCK_MAX))
        begin
            hit = in_range(c, SUPP_EMOJI_MIN, SUPP_EMOJI_MAX);
        end
        else
        begin
            hit = (c == 21'h000A9) || (c == 21'h000AE) ||
                  (c == 21'h0203C) || (c == 21'h02049) ||
                  (c == 21'h02122) || (c == 21'h02139) ||
                  in_range(c, 21'h02194, 21'h02199) ||
                  (c == 21'h021A9) || (c == 21'h021AA) ||
                  (c == 21'h0231A) || (c == 21'h0231B) ||
                  in_range(c, 21'h023E9, 21'h023F3) ||
                  in_range(c, 21'h023F8, 21'h023FA) ||
                  (c == 21'h024C2) ||
                  (c == 21'h025AA) || (c == 21'h025AB) ||
                  (c == 21'h025B6) || (c == 21'h025C0) ||
                  in_range(c, 21'h025FB, 21'h025FE) ||
                  in_range(c, 21'h02600, 21'h027BF) ||
                  in_range(c, 21'h02934, 21'h02935) ||
                  in_range(c, 21'h02B05, 21'h02B07) ||
                  (c == 21'h02B1B) || (c == 21'h02B1C) ||
                  (c == 21'h02B50) || (c == 21'h02B55) ||
                  (c == 21'h03030) || (c == 21'h0303D) ||
                  (c == 21'h03297) || (c == 21'h03299);
        end
        in_emoji_table = hit;
    endfunction

endpackage

// ===== sv/ueec_front.sv =====
// Front end: accepts code units, pairs surrogates and pushes decode entries into the queue.
`timescale 1ns / 1ps

module ueec_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   unit_valid,
    output logic                   unit_ready,
    input  ueec_pkg::in_item_t     unit_data,
    input  ueec_pkg::queue_status_t q_status,
    output logic                   push,
    output ueec_pkg::queue_entry_t push_entry
);
    import ueec_pkg::*;

    logic       held_valid_reg, held_valid_next;
    logic [9:0] held_high_reg, held_high_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    logic       hold_new;

    assign unit_ready = !q_status.full;
    assign accept     = unit_valid && unit_ready;

    // Unit classification
    assign is_high  = (unit_data.code_unit >= HIGH_SURR_MIN) &&
                      (unit_data.code_unit <= HIGH_SURR_MAX);
    assign is_low   = (unit_data.code_unit >= LOW_SURR_MIN) &&
                      (unit_data.code_unit <= LOW_SURR_MAX);
    assign hold_new = is_high && !unit_data.last_unit;

    // Entry build and held-surrogate update
    always_comb
    begin
        held_valid_next     = held_valid_reg;
        held_high_next      = held_high_reg;
        push                = 1'b0;
        push_entry.has_held = 1'b0;
        push_entry.held     = held_high_reg;
        push_entry.has_cp   = 1'b0;
        push_entry.cp       = {5'd0, unit_data.code_unit};
        push_entry.last     = unit_data.last_unit;
        if (accept)
        begin
            if (held_valid_reg && is_low)
            begin
                // completed pair
                push              = 1'b1;
                push_entry.has_cp = 1'b1;
                push_entry.cp     = PAIR_BASE +
                                    {1'b0, held_high_reg, unit_data.code_unit[9:0]};
                held_valid_next   = 1'b0;
                held_high_next    = 10'd0;
            end
            else
            begin
                push_entry.has_held = held_valid_reg;
                push_entry.has_cp   = !hold_new;
                push                = held_valid_reg || !hold_new;
                held_valid_next     = hold_new;
                held_high_next      = hold_new ? unit_data.code_unit[9:0] : 10'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= 10'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

endmodule

// ===== sv/ueec_queue.sv =====
// Short flop-based queue of decode entries between the front and back ends.
`timescale 1ns / 1ps

module ueec_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ueec_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output ueec_pkg::queue_entry_t  head,
    output ueec_pkg::queue_status_t status
);
    import ueec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    queue_entry_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/ueec_back.sv =====
// Back end: expands queue entries into code points, classifies them and drives the output register.
`timescale 1ns / 1ps

module ueec_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ueec_pkg::queue_entry_t  head,
    input  ueec_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    point_valid,
    input  logic                    point_ready,
    output ueec_pkg::out_item_t     point_data
);
    import ueec_pkg::*;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;
    logic        seen_reg, seen_next;
    logic        phase_reg, phase_next;
    logic        load;
    logic        take;
    logic        emit_held;
    logic [20:0] sel_cp;
    logic        sel_last;
    logic        sel_emoji;
    logic        sel_has;

    assign point_valid = out_valid_reg;
    assign point_data  = out_data_reg;

    // Output register free, and an entry waiting
    assign load = !out_valid_reg || point_ready;
    assign take = load && !q_status.empty;

    // Pick the held surrogate first, then the entry's own code point
    assign emit_held = head.has_held && !phase_reg;
    assign sel_cp    = emit_held ? {5'd0, HIGH_SURR_TAG, head.held} : head.cp;
    assign sel_last  = emit_held ? 1'b0 : head.last;
    assign sel_emoji = in_emoji_table(sel_cp);
    assign sel_has   = seen_reg || sel_emoji;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        seen_next      = seen_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = take;
        end
        if (take)
        begin
            out_data_next.codepoint         = sel_cp;
            out_data_next.is_emoji          = sel_emoji;
            out_data_next.message_has_emoji = sel_has;
            out_data_next.last_point        = sel_last;
            seen_next                       = sel_last ? 1'b0 : sel_has;
            if (emit_held && head.has_cp)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
            phase_reg     <= phase_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== sv/utf16_decode_emoji_classify_core.sv =====
// Top level: UTF-16 surrogate pair decoder with emoji classification.
//
//   Channel   Direction  Request type  Handshake
//   unit      in         in_item_t     unit_valid / unit_ready
//   point     out        out_item_t    point_valid / point_ready
//
// One code unit is taken per cycle while the queue is not full. A unit that
// yields two code points (a held high surrogate flushed ahead of another unit)
// occupies the back end's output register once for each; the QUEUE_DEPTH-entry
// queue absorbs that. Each code point passes through the queue and then the
// back end's output register before it is presented.
// rst_n clears the held surrogate, the message emoji flag and the queue.
// A stall on point_ready backs up the queue; unit_ready drops only when it is full.
`timescale 1ns / 1ps

module utf16_decode_emoji_classify_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                unit_valid,
    output logic                unit_ready,
    input  ueec_pkg::in_item_t  unit_data,
    output logic                point_valid,
    input  logic                point_ready,
    output ueec_pkg::out_item_t point_data
);
    import ueec_pkg::*;

    logic          push;
    logic          pop;
    queue_entry_t  push_entry;
    queue_entry_t  head;
    queue_status_t q_status;

    // Decode front end
    ueec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Entry queue
    ueec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Classify back end
    ueec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_data  (point_data)
    );

endmodule

// ===== sv/ueec_checker.sv =====
// Port-level checker for the UTF-16 decoder, bound to the top level.
`timescale 1ns / 1ps

module ueec_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                point_valid,
    input logic                point_ready,
    input ueec_pkg::out_item_t point_data
);
    import ueec_pkg::*;

    // No request shown once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !point_valid)
        else $error("point_valid high during reset");

    // A stalled request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_ready |=> point_valid && $stable(point_data))
        else $error("stalled output request changed");

    // An emoji always sets the message flag
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_data.is_emoji |-> point_data.message_has_emoji)
        else $error("emoji without message flag");

    // Code points stay in the Unicode range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> point_data.codepoint <= 21'h10FFFF)
        else $error("code point out of range");

    // A lone surrogate is never classified as emoji
    a_surr: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && (point_data.codepoint >= {5'd0, HIGH_SURR_MIN}) &&
        (point_data.codepoint <= {5'd0, LOW_SURR_MAX}) |-> !point_data.is_emoji)
        else $error("surrogate classified as emoji");

endmodule

bind utf16_decode_emoji_classify_core ueec_checker u_ueec_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_data  (point_data)
);
